>>> rtl/core/hob_pkg.sv
// ----------------------------------------------------------------------------
// hob_pkg
// Shared types, constants and encoder functions for the hierarchical
// occupancy bitmap.
// ----------------------------------------------------------------------------
package hob_pkg;

  // fixed field widths
  localparam int IDX_W      = 12;
  localparam int KIND_W     = 2;
  localparam int LEAF_COUNT = 64;
  localparam int LEAF_AW    = 6;

  // parameter defaults
  localparam int NUM_BITS_DEF  = 4096;
  localparam int WORD_BITS_DEF = 64;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_SET     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLR     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLR_ALL = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic update;
    logic find;
    logic result;
  } hob_cmd_t;

  // position of the lowest set bit (63 when none is set)
  function automatic logic [LEAF_AW-1:0] low_one(input logic [63:0] w);
    logic [LEAF_AW-1:0] res;
    res = LEAF_AW'(63);
    for (int i = 63; i >= 0; i--) begin
      if (w[i]) res = LEAF_AW'(i);
    end
    return res;
  endfunction

  // position of the highest set bit (0 when none is set)
  function automatic logic [LEAF_AW-1:0] high_one(input logic [63:0] w);
    logic [LEAF_AW-1:0] res;
    res = '0;
    for (int i = 0; i < 64; i++) begin
      if (w[i]) res = LEAF_AW'(i);
    end
    return res;
  endfunction

endpackage

>>> rtl/core/hob_ram.sv
// ----------------------------------------------------------------------------
// hob_ram
// Generic RAM with one write port and two read ports, registered read data.
// ----------------------------------------------------------------------------
module hob_ram #(
  parameter int WIDTH = hob_pkg::WORD_BITS_DEF,
  parameter int DEPTH = hob_pkg::LEAF_COUNT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

>>> rtl/core/hob_ctrl.sv
// ----------------------------------------------------------------------------
// hob_ctrl
// Sequencer for the bitmap: accept, leaf update, summary encode, result load.
// ----------------------------------------------------------------------------
module hob_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output hob_pkg::hob_cmd_t cmd
);
  import hob_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_FIND = 2'd2;
  localparam logic [1:0] ST_RES  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;
  logic       accept_ok;
  logic       accept;

  // handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign accept_ok = (state_r == ST_IDLE) || ((state_r == ST_RES) && out_free);
  assign in_stall  = !accept_ok;
  assign accept    = in_valid && accept_ok;
  assign out_valid = out_valid_r;

  // commands
  always_comb begin
    cmd.load_item = accept;
    cmd.update    = (state_r == ST_UPD);
    cmd.find      = (state_r == ST_FIND);
    cmd.result    = (state_r == ST_RES) && out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_UPD;
      end
      ST_UPD:  state_nxt = ST_FIND;
      ST_FIND: state_nxt = ST_RES;
      ST_RES: begin
        if (out_free) state_nxt = accept ? ST_UPD : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.result) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/hob_datapath.sv
// ----------------------------------------------------------------------------
// hob_datapath
// Summary word, leaf word memory, index split and the two-level encoders.
// ----------------------------------------------------------------------------
module hob_datapath #(
  parameter int NUM_BITS  = hob_pkg::NUM_BITS_DEF,
  parameter int WORD_BITS = hob_pkg::WORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hob_pkg::hob_cmd_t         cmd,
  input  logic [hob_pkg::KIND_W-1:0] in_kind,
  input  logic [hob_pkg::IDX_W-1:0]  in_bit_index,
  output logic                      out_is_empty,
  output logic [hob_pkg::IDX_W-1:0]  out_lowest_set,
  output logic [hob_pkg::IDX_W-1:0]  out_highest_set
);
  import hob_pkg::*;

  localparam int POS_W  = $clog2(WORD_BITS);
  localparam int CAP    = LEAF_COUNT * WORD_BITS;
  localparam int USABLE = (NUM_BITS < CAP) ? NUM_BITS : CAP;

  // item registers
  logic [KIND_W-1:0]     kind_r;
  logic [LEAF_AW-1:0]    leaf_r;
  logic [POS_W-1:0]      pos_r;
  logic                  in_range_r;

  // store and lookup registers
  logic [LEAF_COUNT-1:0] summary_r;
  logic [LEAF_COUNT-1:0] summary_nxt;
  logic [LEAF_AW-1:0]    lo_leaf_r;
  logic [LEAF_AW-1:0]    hi_leaf_r;
  logic                  empty_r;

  // result registers
  logic                  out_is_empty_r;
  logic [IDX_W-1:0]      out_lowest_set_r;
  logic [IDX_W-1:0]      out_highest_set_r;

  logic [IDX_W:0]        rem;
  logic [LEAF_AW-1:0]    quot;
  logic                  in_range;
  logic [LEAF_AW-1:0]    lo_leaf;
  logic [LEAF_AW-1:0]    hi_leaf;
  logic [LEAF_AW-1:0]    raddr_a;
  logic [WORD_BITS-1:0]  rdata_a;
  logic [WORD_BITS-1:0]  rdata_b;
  logic [WORD_BITS-1:0]  cur_word;
  logic [WORD_BITS-1:0]  bit_mask;
  logic [WORD_BITS-1:0]  new_word;
  logic                  wr_en;

  // split index into leaf and position by restoring compare and subtract
  always_comb begin
    rem  = {1'b0, in_bit_index};
    quot = '0;
    for (int b = LEAF_AW - 1; b >= 0; b--) begin
      if (rem >= ((IDX_W + 1)'(WORD_BITS) << b)) begin
        rem     = rem - ((IDX_W + 1)'(WORD_BITS) << b);
        quot[b] = 1'b1;
      end
    end
  end

  assign in_range = {1'b0, in_bit_index} < (IDX_W + 1)'(USABLE);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r     <= in_kind;
      leaf_r     <= quot;
      pos_r      <= rem[POS_W-1:0];
      in_range_r <= in_range;
    end
  end

  // leaf update; a leaf unmarked in the summary reads as zero
  assign cur_word = summary_r[leaf_r] ? rdata_a : '0;
  assign bit_mask = WORD_BITS'(1) << pos_r;

  always_comb begin
    new_word    = cur_word;
    summary_nxt = summary_r;
    wr_en       = 1'b0;
    case (kind_r)
      KIND_SET: begin
        if (in_range_r) begin
          new_word            = cur_word | bit_mask;
          summary_nxt[leaf_r] = 1'b1;
          wr_en               = 1'b1;
        end
      end
      KIND_CLR: begin
        if (in_range_r) begin
          new_word            = cur_word & ~bit_mask;
          summary_nxt[leaf_r] = |new_word;
          wr_en               = 1'b1;
        end
      end
      KIND_CLR_ALL: summary_nxt = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      summary_r <= '0;
    end else if (cmd.update) begin
      summary_r <= summary_nxt;
    end
  end

  // summary encode picks the leaves to read back
  assign lo_leaf = low_one(summary_r);
  assign hi_leaf = high_one(summary_r);
  assign raddr_a = cmd.load_item ? quot : lo_leaf;

  always_ff @(posedge clk) begin
    if (cmd.find) begin
      lo_leaf_r <= lo_leaf;
      hi_leaf_r <= hi_leaf;
      empty_r   <= ~|summary_r;
    end
  end

  hob_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (LEAF_COUNT)
  ) u_leaf_ram (
    .clk     (clk),
    .we      (cmd.update && wr_en),
    .waddr   (leaf_r),
    .wdata   (new_word),
    .raddr_a (raddr_a),
    .raddr_b (hi_leaf),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // leaf encode and result load
  always_ff @(posedge clk) begin
    if (cmd.result) begin
      out_is_empty_r <= empty_r;
      if (empty_r) begin
        out_lowest_set_r  <= '0;
        out_highest_set_r <= '0;
      end else begin
        out_lowest_set_r  <= IDX_W'(int'(lo_leaf_r) * WORD_BITS
                                    + int'(low_one(64'(rdata_a))));
        out_highest_set_r <= IDX_W'(int'(hi_leaf_r) * WORD_BITS
                                    + int'(high_one(64'(rdata_b))));
      end
    end
  end

  assign out_is_empty    = out_is_empty_r;
  assign out_lowest_set  = out_lowest_set_r;
  assign out_highest_set = out_highest_set_r;

endmodule

>>> rtl/core/hierarchical_occupancy_bitmap_top.sv
// ----------------------------------------------------------------------------
// hierarchical_occupancy_bitmap_top
// Two-level occupancy bitmap with set, clear and clear-all items that
// reports emptiness and the lowest and highest set position.
// ----------------------------------------------------------------------------
// Usage
//   input channel : in_valid / in_stall, payload in_kind and in_bit_index
//   output channel: out_valid / out_stall, payload out_is_empty,
//                   out_lowest_set and out_highest_set
//   A transfer completes on a clock edge with valid high and stall low.
//   Every input item gives exactly one result, in order.
//   Steps from the input transfer to out_valid: leaf read, leaf write and
//   summary update, summary encode with the two leaf reads, leaf encode
//   into the output register.
//   A new item can be taken in the result step of the last one; each item
//   needs a chain of two registered reads of the leaf word memory.
//   One finished result may wait in the output register while the next
//   item is taken and worked on; while it waits under out_stall the next
//   result holds in the last step and in_stall stays high.
//   Reset (rst_n low, synchronous) empties the store at once by clearing
//   the summary word; no clearing pass is needed.
// ----------------------------------------------------------------------------
module hierarchical_occupancy_bitmap_top #(
  parameter int NUM_BITS  = hob_pkg::NUM_BITS_DEF,
  parameter int WORD_BITS = hob_pkg::WORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [hob_pkg::KIND_W-1:0] in_kind,
  input  logic [hob_pkg::IDX_W-1:0]  in_bit_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_is_empty,
  output logic [hob_pkg::IDX_W-1:0]  out_lowest_set,
  output logic [hob_pkg::IDX_W-1:0]  out_highest_set
);
  import hob_pkg::*;

  hob_cmd_t cmd;

  hob_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  hob_datapath #(
    .NUM_BITS  (NUM_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_kind         (in_kind),
    .in_bit_index    (in_bit_index),
    .out_is_empty    (out_is_empty),
    .out_lowest_set  (out_lowest_set),
    .out_highest_set (out_highest_set)
  );

`ifndef SYNTHESIS
  // an accepted item goes into the update step next
  a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> cmd.update)
    else $error("accepted item did not reach the update step");

  // the update step is followed by the summary encode step
  a_update_find: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> cmd.find)
    else $error("update not followed by summary encode");

  // in the result step input is blocked only by a held result
  a_find_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.find |=> (in_stall == (out_valid && out_stall)))
    else $error("result step stall mismatch");

  // a loaded result is offered on the next cycle
  a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result |=> out_valid)
    else $error("result loaded but not offered");

  // at most one work step at a time
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.update, cmd.find, cmd.result}))
    else $error("overlapping work steps");
`endif

endmodule

>>> bench/tb_hierarchical_occupancy_bitmap_top.sv
// ----------------------------------------------------------------------------
// tb_hierarchical_occupancy_bitmap_top
// Self-checking bench for the two-level occupancy bitmap. A scoreboard keeps
// its own leaf words and summary word, works out the empty flag and the
// lowest and highest set position for every input transfer, and compares
// each output transfer against the oldest outstanding prediction. Both
// channels idle and stall at random, with one long output hold-off and one
// input pause that lets the block drain.
// ----------------------------------------------------------------------------
module tb_hierarchical_occupancy_bitmap_top;

  localparam int IDX_W        = hob_pkg::IDX_W;
  localparam int KIND_W       = hob_pkg::KIND_W;
  localparam int NUM_BITS     = hob_pkg::NUM_BITS_DEF;
  localparam int WORD_BITS    = hob_pkg::WORD_BITS_DEF;
  localparam int USABLE_BITS  = (NUM_BITS < 64 * WORD_BITS) ? NUM_BITS : 64 * WORD_BITS;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1075;
  localparam int PAUSE_AT     = 600;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic             empty;
    logic [IDX_W-1:0] lowest;
    logic [IDX_W-1:0] highest;
  } occupancy_t;

  // occupancy predictor and store of pending results
  class occupancy_board;
    bit [63:0]  leaf_word [64];
    bit [63:0]  summary;
    occupancy_t pending_q[$];
    int         errors;

    function new();
      clear_store();
      errors = 0;
    endfunction

    function void clear_store();
      foreach (leaf_word[i]) leaf_word[i] = '0;
      summary = '0;
    endfunction

    // apply one input transfer and queue the occupancy it leaves behind
    function void note_input(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx);
      int         leaf;
      int         pos;
      int         lo_leaf;
      int         hi_leaf;
      int         lo_pos;
      int         hi_pos;
      occupancy_t want;
      leaf = int'(idx) / WORD_BITS;
      pos  = int'(idx) % WORD_BITS;
      if (kind == hob_pkg::KIND_CLR_ALL) begin
        clear_store();
      end else if ((kind == hob_pkg::KIND_SET || kind == hob_pkg::KIND_CLR) &&
                   int'(idx) < USABLE_BITS) begin
        if (kind == hob_pkg::KIND_SET) begin
          leaf_word[leaf][pos] = 1'b1;
          summary[leaf] = 1'b1;
        end else begin
          leaf_word[leaf][pos] = 1'b0;
          if (leaf_word[leaf] == '0) summary[leaf] = 1'b0;
        end
      end
      // two-level search for the extremes
      if (summary == '0) begin
        want = '{empty: 1'b1, lowest: '0, highest: '0};
      end else begin
        lo_leaf = 0;
        hi_leaf = 0;
        lo_pos = 0;
        hi_pos = 0;
        for (int i = 63; i >= 0; i--) if (summary[i]) lo_leaf = i;
        for (int i = 0; i < 64; i++) if (summary[i]) hi_leaf = i;
        for (int i = 63; i >= 0; i--) if (leaf_word[lo_leaf][i]) lo_pos = i;
        for (int i = 0; i < 64; i++) if (leaf_word[hi_leaf][i]) hi_pos = i;
        want.empty   = 1'b0;
        want.lowest  = IDX_W'(lo_leaf * WORD_BITS + lo_pos);
        want.highest = IDX_W'(hi_leaf * WORD_BITS + hi_pos);
      end
      pending_q.push_back(want);
    endfunction

    // compare one output transfer with the oldest prediction
    function void check_result(logic empty, logic [IDX_W-1:0] lowest,
                               logic [IDX_W-1:0] highest);
      occupancy_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result: empty %b lowest %0d highest %0d",
                 $time, empty, lowest, highest);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (empty !== want.empty) begin
        $display("%0t: is_empty mismatch: expected %b actual %b", $time, want.empty, empty);
        errors++;
      end
      if (lowest !== want.lowest) begin
        $display("%0t: lowest_set mismatch: expected %0d actual %0d",
                 $time, want.lowest, lowest);
        errors++;
      end
      if (highest !== want.highest) begin
        $display("%0t: highest_set mismatch: expected %0d actual %0d",
                 $time, want.highest, highest);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [KIND_W-1:0] in_kind;
  logic [IDX_W-1:0]  in_bit_index;
  logic              out_valid;
  logic              out_stall;
  logic              out_is_empty;
  logic [IDX_W-1:0]  out_lowest_set;
  logic [IDX_W-1:0]  out_highest_set;

  wire in_accept  = in_valid && !in_stall;
  wire out_accept = out_valid && !out_stall;

  occupancy_board board;
  int             sent_count;

  hierarchical_occupancy_bitmap_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_bit_index    (in_bit_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_is_empty    (out_is_empty),
    .out_lowest_set  (out_lowest_set),
    .out_highest_set (out_highest_set)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // offer one item after a random or zero gap and hold it until the transfer
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx);
    int gap;
    gap = (((sent_count / 100) % 4) == 2) ? 0 : int'($urandom_range(0, 11));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_bit_index <= idx;
    @(posedge clk);
    while (!in_accept) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  // transfer monitor feeding the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_accept) board.note_input(in_kind, in_bit_index);
      if (out_accept) board.check_result(out_is_empty, out_lowest_set, out_highest_set);
    end
  end

  // result side stalls, with one long hold-off that backs up the input
  initial begin : receiver
    int gap;
    int taken;
    bit held;
    out_stall = 1'b0;
    taken = 0;
    held = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!held && taken >= HOLD_AFTER) begin
        gap = HOLD_CYCLES;
        held = 1'b1;
      end else if (((taken / 150) % 4) == 3) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 11);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_accept) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  // watchdog on cycles without any transfer
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (in_accept || out_accept) idle = 0;
      else idle++;
    end
    $display("simulation failed");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int               focus;
    int               r;
    int               pick;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  set_log[$];

    in_valid     = 1'b0;
    in_kind      = hob_pkg::KIND_SET;
    in_bit_index = '0;
    rst_n        = 1'b0;
    sent_count   = 0;
    board        = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, leaf boundaries, leaf emptying, unused kind, clear-all
    send_item(hob_pkg::KIND_SET, 12'd0);
    send_item(hob_pkg::KIND_SET, 12'd4095);
    send_item(hob_pkg::KIND_CLR, 12'd4095);
    send_item(hob_pkg::KIND_CLR, 12'd0);
    send_item(hob_pkg::KIND_CLR, 12'd0);
    send_item(hob_pkg::KIND_SET, 12'd63);
    send_item(hob_pkg::KIND_SET, 12'd64);
    send_item(hob_pkg::KIND_SET, 12'd64);
    send_item(hob_pkg::KIND_CLR, 12'd63);
    send_item(KIND_UNUSED, 12'd100);
    send_item(hob_pkg::KIND_SET, 12'd4032);
    send_item(hob_pkg::KIND_SET, 12'd4095);
    send_item(hob_pkg::KIND_CLR, 12'd4032);
    send_item(hob_pkg::KIND_CLR_ALL, 12'd4095);
    send_item(hob_pkg::KIND_SET, 12'd2047);
    send_item(hob_pkg::KIND_SET, 12'd2048);
    send_item(hob_pkg::KIND_CLR, 12'd1000);
    send_item(hob_pkg::KIND_CLR, 12'd2049);
    send_item(KIND_UNUSED, 12'd0);
    send_item(hob_pkg::KIND_CLR_ALL, 12'd0);
    send_item(KIND_UNUSED, 12'd4095);
    send_item(hob_pkg::KIND_SET, 12'd4095);
    send_item(hob_pkg::KIND_SET, 12'd0);
    send_item(hob_pkg::KIND_CLR_ALL, 12'd2730);

    // random: sets and clears, many clustered around a wandering focus leaf, and some clear-all and unused items
    focus = $urandom_range(0, 63);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // let the block drain completely once
      if (n == PAUSE_AT) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (board.pending_q.size() != 0) @(negedge clk);
      end
      if ($urandom_range(0, 49) == 0) focus = $urandom_range(0, 63);
      r = $urandom_range(0, 99);
      idx = IDX_W'($urandom);
      if (r < 1) begin
        kind = hob_pkg::KIND_CLR_ALL;
        set_log.delete();
      end else if (r < 3) begin
        kind = KIND_UNUSED;
      end else if (r < 52) begin
        kind = hob_pkg::KIND_SET;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          idx = IDX_W'(((focus + $urandom_range(0, 4) + 62) % 64) * WORD_BITS +
                       $urandom_range(0, WORD_BITS - 1));
        end else if (pick < 7) begin
          idx = IDX_W'($urandom_range(0, 63) * WORD_BITS +
                       ($urandom_range(0, 1) ? WORD_BITS - 1 : 0));
        end
        set_log.push_back(idx);
        if (set_log.size() > 96) void'(set_log.pop_front());
      end else begin
        kind = hob_pkg::KIND_CLR;
        if (set_log.size() > 0 && $urandom_range(0, 9) < 7) begin
          pick = $urandom_range(0, set_log.size() - 1);
          idx = set_log[pick];
          set_log.delete(pick);
        end
      end
      send_item(kind, idx);
    end

    // wait for the last results, then let the pipeline settle
    in_valid <= 1'b0;
    while (board.pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
